### design/mandelbrot_escape_time_assert.svh
// Assertion macros for the Mandelbrot escape-time block.
// Included by the top level; needs nothing else.
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define MBET_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mbet: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset
`define MBET_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mbet: next-cycle check failed");

`endif

### design/mbet_pkg.sv
// Shared types and constants for the Mandelbrot escape-time block.
// No dependencies; imported by every module of the block.
package mbet_pkg;

   // Fixed field widths
   localparam int INDEX_BITS        = 12;
   localparam int COUNT_BITS        = 12;
   localparam int INT_BITS          = 4;   // integer bits of the Q4.F word
   localparam int FRAC_BITS_DEFAULT = 28;
   localparam int DIGIT_BITS        = 16;  // multiplier digit per chain cell

   // Register port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_RE      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_IM      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_RE        = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_IM        = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_ITERATIONS = 3'd4;

   typedef struct packed {
      logic [INDEX_BITS-1:0] column;
      logic [INDEX_BITS-1:0] row;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] iteration_count;
      logic                  escaped;
   } rsp_type;

   // Origins hold two's complement bit patterns
   typedef struct packed {
      logic [31:0]           origin_re;
      logic [31:0]           origin_im;
      logic [30:0]           step_re;
      logic [30:0]           step_im;
      logic [COUNT_BITS-1:0] max_iterations;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      origin_re:      32'(-199702558),
      origin_im:      32'(35084514),
      step_re:        31'(2397),
      step_im:        31'(4628),
      max_iterations: COUNT_BITS'(1001)
   };

endpackage

### design/mbet_cell.sv
// One cell of a multiplier chain: adds a times one 16-bit digit of b,
// shifted to the digit's weight, to the running sum. Uses mbet_pkg.
module mbet_cell import mbet_pkg::*; #(
   parameter int WORD_BITS = FRAC_BITS_DEFAULT + INT_BITS,
   parameter int B_BITS    = 2 * DIGIT_BITS,
   parameter int DIGIT_IDX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid_in,
   input  logic [WORD_BITS-1:0]   a_in,
   input  logic [B_BITS-1:0]      b_in,
   input  logic [2*WORD_BITS-1:0] acc_in,
   output logic                   valid_out,
   output logic [WORD_BITS-1:0]   a_out,
   output logic [B_BITS-1:0]      b_out,
   output logic [2*WORD_BITS-1:0] acc_out
);

   localparam int  ACC_BITS  = 2 * WORD_BITS;
   localparam int  PART_BITS = WORD_BITS + DIGIT_BITS + 1;
   localparam int  SHIFT     = DIGIT_IDX * DIGIT_BITS;
   localparam bit  TOP       = (DIGIT_IDX == B_BITS / DIGIT_BITS - 1);

   logic [DIGIT_BITS-1:0]   digit;
   logic signed [DIGIT_BITS:0] digit_s;
   logic signed [PART_BITS-1:0] part;
   logic [ACC_BITS-1:0]     part_ext;
   logic [ACC_BITS-1:0]     acc_in_sum;

   logic                    valid_ff;
   logic [WORD_BITS-1:0]    a_ff;
   logic [B_BITS-1:0]       b_ff;
   logic [ACC_BITS-1:0]     acc_ff;

   // Top digit carries the sign of b, lower digits are unsigned
   assign digit   = b_in[SHIFT +: DIGIT_BITS];
   assign digit_s = TOP ? $signed({digit[DIGIT_BITS-1], digit}) : $signed({1'b0, digit});

   // Partial product, sign-extended and weighted; sum wraps at full width
   assign part       = PART_BITS'($signed(a_in)) * PART_BITS'(digit_s);
   assign part_ext   = {{(ACC_BITS-PART_BITS){part[PART_BITS-1]}}, part};
   assign acc_in_sum = acc_in + (part_ext << SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in_sum;
   end

   assign valid_out = valid_ff;
   assign a_out     = a_ff;
   assign b_out     = b_ff;
   assign acc_out   = acc_ff;

endmodule

### design/mbet_chain.sv
// Signed WORD_BITS x WORD_BITS multiplier built as a row of mbet_cell
// stages, one 16-bit digit of b per cell. Uses mbet_pkg and mbet_cell.
module mbet_chain import mbet_pkg::*; #(
   parameter int WORD_BITS = FRAC_BITS_DEFAULT + INT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [WORD_BITS-1:0]   a_in,
   input  logic [WORD_BITS-1:0]   b_in,
   output logic                   out_valid,
   output logic [2*WORD_BITS-1:0] prod_out
);

   localparam int NUM_DIGITS = (WORD_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int B_BITS     = NUM_DIGITS * DIGIT_BITS;

   logic                   v_w   [0:NUM_DIGITS];
   logic [2*WORD_BITS-1:0] acc_w [0:NUM_DIGITS];
   logic [WORD_BITS-1:0]   a_w   [0:NUM_DIGITS-1];
   logic [B_BITS-1:0]      b_w   [0:NUM_DIGITS-1];

   // b padded to whole digits by sign extension
   assign v_w[0]   = in_valid;
   assign acc_w[0] = '0;
   assign a_w[0]   = a_in;
   assign b_w[0]   = {{(B_BITS-WORD_BITS){b_in[WORD_BITS-1]}}, b_in};

   for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
      if (k < NUM_DIGITS - 1) begin : g_mid
         mbet_cell #(
            .WORD_BITS (WORD_BITS),
            .B_BITS    (B_BITS),
            .DIGIT_IDX (k)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .valid_in  (v_w[k]),
            .a_in      (a_w[k]),
            .b_in      (b_w[k]),
            .acc_in    (acc_w[k]),
            .valid_out (v_w[k+1]),
            .a_out     (a_w[k+1]),
            .b_out     (b_w[k+1]),
            .acc_out   (acc_w[k+1])
         );
      end else begin : g_last
         // last cell: operands go no further
         mbet_cell #(
            .WORD_BITS (WORD_BITS),
            .B_BITS    (B_BITS),
            .DIGIT_IDX (k)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .valid_in  (v_w[k]),
            .a_in      (a_w[k]),
            .b_in      (b_w[k]),
            .acc_in    (acc_w[k]),
            .valid_out (v_w[k+1]),
            .a_out     (),
            .b_out     (),
            .acc_out   (acc_w[k+1])
         );
      end
   end

   assign out_valid = v_w[NUM_DIGITS];
   assign prod_out  = acc_w[NUM_DIGITS];

endmodule

### design/mbet_seq.sv
// Iteration sequencer: forms c from the pixel index, issues x*x, y*y and
// x*y to the multiplier chains, updates z and the count. Uses mbet_pkg.
module mbet_seq import mbet_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cfg_type                               cfg,
   input  logic                                  start,
   output logic                                  busy,
   input  req_type                               req_data,
   output logic                                  rsp_valid,
   output rsp_type                               rsp_data,
   output logic                                  issue_valid,
   output logic [FRAC_BITS+INT_BITS-1:0]         x_op,
   output logic [FRAC_BITS+INT_BITS-1:0]         y_op,
   input  logic                                  prod_valid,
   input  logic [2*(FRAC_BITS+INT_BITS)-1:0]     xx_prod,
   input  logic [2*(FRAC_BITS+INT_BITS)-1:0]     yy_prod,
   input  logic [2*(FRAC_BITS+INT_BITS)-1:0]     xy_prod
);

   localparam int WORD_BITS = FRAC_BITS + INT_BITS;
   localparam int MUL_BITS  = 31 + INDEX_BITS;
   localparam int EXT_BITS  = WORD_BITS + MUL_BITS;
   localparam int SQ_BITS   = WORD_BITS + 3;

   // |z|^2 bound of 4.0
   localparam logic [SQ_BITS:0] ESC_LIMIT =
      {{(WORD_BITS+1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS+2){1'b0}}};

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_POINT = 2'd1;
   localparam logic [1:0] ST_ISSUE = 2'd2;
   localparam logic [1:0] ST_WAIT  = 2'd3;

   logic [1:0]            state_ff,     state_in;
   req_type               req_ff,       req_in;
   logic [WORD_BITS-1:0]  cx_ff,        cx_in;
   logic [WORD_BITS-1:0]  cy_ff,        cy_in;
   logic [WORD_BITS-1:0]  x_ff,         x_in;
   logic [WORD_BITS-1:0]  y_ff,         y_in;
   logic [COUNT_BITS-1:0] count_ff,     count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff,       rsp_in;

   logic [MUL_BITS-1:0]   re_prod, im_prod;
   logic [EXT_BITS-1:0]   org_re_ext, org_im_ext, re_prod_ext, im_prod_ext;
   logic [WORD_BITS-1:0]  c_re, c_im;
   logic [SQ_BITS-1:0]    xx_sq, yy_sq;
   logic [SQ_BITS:0]      mag_sum;
   logic                  escape;
   logic [WORD_BITS-1:0]  x_next, y_next;
   logic                  below_limit;

   // c = origin + step * index, wrapped into the word
   assign re_prod     = MUL_BITS'(cfg.step_re) * MUL_BITS'(req_ff.column);
   assign im_prod     = MUL_BITS'(cfg.step_im) * MUL_BITS'(req_ff.row);
   assign org_re_ext  = {{(EXT_BITS-32){cfg.origin_re[31]}}, cfg.origin_re};
   assign org_im_ext  = {{(EXT_BITS-32){cfg.origin_im[31]}}, cfg.origin_im};
   assign re_prod_ext = {{(EXT_BITS-MUL_BITS){1'b0}}, re_prod};
   assign im_prod_ext = {{(EXT_BITS-MUL_BITS){1'b0}}, im_prod};
   assign c_re        = org_re_ext[WORD_BITS-1:0] + re_prod_ext[WORD_BITS-1:0];
   assign c_im        = org_im_ext[WORD_BITS-1:0] + im_prod_ext[WORD_BITS-1:0];

   // Escape test on floor(x*x) + floor(y*y), exact
   assign xx_sq   = xx_prod[FRAC_BITS +: SQ_BITS];
   assign yy_sq   = yy_prod[FRAC_BITS +: SQ_BITS];
   assign mag_sum = {1'b0, xx_sq} + {1'b0, yy_sq};
   assign escape  = (mag_sum >= ESC_LIMIT);

   // z update; 2*x*y is x*y shifted one bit less
   assign x_next = xx_prod[FRAC_BITS +: WORD_BITS] - yy_prod[FRAC_BITS +: WORD_BITS] + cx_ff;
   assign y_next = xy_prod[FRAC_BITS-1 +: WORD_BITS] + cy_ff;

   assign below_limit = (count_ff < cfg.max_iterations);

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_POINT;
            end
         end
         ST_POINT: begin
            cx_in    = c_re;
            cy_in    = c_im;
            x_in     = c_re;
            y_in     = c_im;
            count_in = '0;
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            if (below_limit) begin
               state_in = ST_WAIT;
            end else begin
               // limit reached: inside the set
               rsp_valid_in           = 1'b1;
               rsp_in.iteration_count = count_ff;
               rsp_in.escaped         = 1'b0;
               state_in               = ST_IDLE;
            end
         end
         ST_WAIT: begin
            if (prod_valid) begin
               if (escape) begin
                  rsp_valid_in           = 1'b1;
                  rsp_in.iteration_count = count_ff;
                  rsp_in.escaped         = 1'b1;
                  state_in               = ST_IDLE;
               end else begin
                  x_in     = x_next;
                  y_in     = y_next;
                  count_in = count_ff + COUNT_BITS'(1);
                  state_in = ST_ISSUE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;
   assign issue_valid = (state_ff == ST_ISSUE) && below_limit;
   assign x_op        = x_ff;
   assign y_op        = y_ff;

endmodule

### design/mandelbrot_escape_time.sv
// Mandelbrot escape-time iteration, one pixel at a time. A pixel is taken
// when start is high and busy is low; its result appears on rsp_data for
// exactly one cycle with rsp_valid high and must be captured then. Each
// iteration of z = z*z + c passes through the multiplier cell chains, each
// of NUM_DIGITS cells, where NUM_DIGITS = ceil((FRAC_BITS + 4) / 16) and
// the default word format is Q4.28.
// A new pixel is taken in the same cycle its predecessor's result is shown.
// Registers are written over the csr_ channel while busy is low.
// Files: mbet_pkg, mbet_cell, mbet_chain, mbet_seq and the assertion header.
`include "mandelbrot_escape_time_assert.svh"

module mandelbrot_escape_time import mbet_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int WORD_BITS = FRAC_BITS + INT_BITS;

   cfg_type                cfg_ff, cfg_in;
   logic                   issue_valid;
   logic [WORD_BITS-1:0]   x_op, y_op;
   logic                   xx_valid, yy_valid, xy_valid;
   logic [2*WORD_BITS-1:0] xx_prod, yy_prod, xy_prod;

   // Register writes; unknown indexes are dropped
   assign csr_ready = ~busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ORIGIN_RE:      cfg_in.origin_re      = csr_wdata;
            CSR_ORIGIN_IM:      cfg_in.origin_im      = csr_wdata;
            CSR_STEP_RE:        cfg_in.step_re        = csr_wdata[30:0];
            CSR_STEP_IM:        cfg_in.step_im        = csr_wdata[30:0];
            CSR_MAX_ITERATIONS: cfg_in.max_iterations = csr_wdata[COUNT_BITS-1:0];
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mbet_seq #(
      .FRAC_BITS (FRAC_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .issue_valid (issue_valid),
      .x_op        (x_op),
      .y_op        (y_op),
      .prod_valid  (xx_valid),
      .xx_prod     (xx_prod),
      .yy_prod     (yy_prod),
      .xy_prod     (xy_prod)
   );

   // Three chains run in lockstep: x*x, y*y, x*y
   mbet_chain #(.WORD_BITS (WORD_BITS)) u_chain_xx (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (issue_valid),
      .a_in      (x_op),
      .b_in      (x_op),
      .out_valid (xx_valid),
      .prod_out  (xx_prod)
   );

   mbet_chain #(.WORD_BITS (WORD_BITS)) u_chain_yy (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (issue_valid),
      .a_in      (y_op),
      .b_in      (y_op),
      .out_valid (yy_valid),
      .prod_out  (yy_prod)
   );

   mbet_chain #(.WORD_BITS (WORD_BITS)) u_chain_xy (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (issue_valid),
      .a_in      (x_op),
      .b_in      (y_op),
      .out_valid (xy_valid),
      .prod_out  (xy_prod)
   );

   // Checks
   `MBET_ASSERT_IMPL(a_chains_lockstep, clock, reset, xx_valid, yy_valid && xy_valid)
   `MBET_ASSERT_IMPL(a_product_while_busy, clock, reset, xx_valid || yy_valid || xy_valid, busy)
   `MBET_ASSERT_NEXT(a_single_result, clock, reset, rsp_valid, !rsp_valid)
   `MBET_ASSERT_IMPL(a_escape_below_limit, clock, reset, rsp_valid && rsp_data.escaped,
                     rsp_data.iteration_count < cfg_ff.max_iterations)

endmodule
